// File: hw/rtl/b64d_pkg.sv
// b64d_pkg: types and character constants for the custom-alphabet base64 decoder
// used by b64d_decode and custom_alphabet_base64_decoder; no dependencies
package b64d_pkg;

  localparam logic [7:0] CH_LOW_A  = 8'h61;  // 'a'
  localparam logic [7:0] CH_LOW_Z  = 8'h7a;  // 'z'
  localparam logic [7:0] CH_UP_A   = 8'h41;  // 'A'
  localparam logic [7:0] CH_UP_Z   = 8'h5a;  // 'Z'
  localparam logic [7:0] CH_DIG_0  = 8'h30;  // '0'
  localparam logic [7:0] CH_DIG_9  = 8'h39;  // '9'
  localparam logic [7:0] CH_LBRACK = 8'h5b;  // '['
  localparam logic [7:0] CH_RBRACK = 8'h5d;  // ']'

  localparam logic [5:0] VAL_UP_BASE  = 6'd26;
  localparam logic [5:0] VAL_DIG_BASE = 6'd52;
  localparam logic [5:0] VAL_LBRACK   = 6'd62;
  localparam logic [5:0] VAL_RBRACK   = 6'd63;

  localparam logic [1:0] PHASE_LAST = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       run_last;
    logic       message_end;
    logic       bad_char;
  } result_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] partial_byte;
    logic       drop_until_end;
  } dec_state_t;

  typedef struct packed {
    logic [1:0] num;   // results produced by this item, 0 to 2
    result_t    res0;
    result_t    res1;
  } dec_out_t;

endpackage

// File: hw/rtl/b64d_decode.sv
// b64d_decode: per-character decode logic, symbol lookup, state update, results
// depends on b64d_pkg
module b64d_decode import b64d_pkg::*; (
  input  logic [7:0] char_code,
  input  logic       end_of_message,
  input  dec_state_t st,
  output dec_state_t st_nxt,
  output dec_out_t   dout
);

  logic [5:0] sym;
  logic       sym_ok;
  logic [7:0] byte_val;
  logic [7:0] pb_nxt;
  logic       have_byte;

  always_comb begin
    sym    = '0;
    sym_ok = 1'b1;
    case (char_code) inside
      [CH_LOW_A:CH_LOW_Z]: sym = 6'(char_code - CH_LOW_A);
      [CH_UP_A:CH_UP_Z]:   sym = 6'(char_code - CH_UP_A) + VAL_UP_BASE;
      [CH_DIG_0:CH_DIG_9]: sym = 6'(char_code - CH_DIG_0) + VAL_DIG_BASE;
      CH_LBRACK:           sym = VAL_LBRACK;
      CH_RBRACK:           sym = VAL_RBRACK;
      default:             sym_ok = 1'b0;
    endcase
  end

  always_comb begin
    byte_val  = '0;
    pb_nxt    = '0;
    have_byte = 1'b0;
    case (st.phase)
      2'd0: begin
        pb_nxt = {sym, 2'b00};
      end
      2'd1: begin
        byte_val  = st.partial_byte | {6'b0, sym[5:4]};
        pb_nxt    = {sym[3:0], 4'b0000};
        have_byte = 1'b1;
      end
      2'd2: begin
        byte_val  = st.partial_byte | {4'b0, sym[5:2]};
        pb_nxt    = {sym[1:0], 6'b000000};
        have_byte = 1'b1;
      end
      default: begin
        byte_val  = st.partial_byte | {2'b00, sym};
        have_byte = 1'b1;
      end
    endcase
  end

  always_comb begin
    st_nxt = st;
    dout   = '0;
    if (st.drop_until_end) begin
      st_nxt.drop_until_end = !end_of_message;
    end else if (!sym_ok) begin
      dout.num  = 2'd1;
      dout.res0 = '{data_byte: 8'h00, run_last: 1'b1, message_end: 1'b1, bad_char: 1'b1};
      st_nxt    = '{phase: 2'd0, partial_byte: 8'h00, drop_until_end: !end_of_message};
    end else if (!end_of_message) begin
      st_nxt.phase        = st.phase + 2'd1;
      st_nxt.partial_byte = pb_nxt;
      dout.num            = {1'b0, have_byte};
      dout.res0           = '{data_byte: byte_val, run_last: 1'b1,
                              message_end: 1'b0, bad_char: 1'b0};
    end else begin
      st_nxt = '{phase: 2'd0, partial_byte: 8'h00, drop_until_end: 1'b0};
      if (st.phase == PHASE_LAST) begin
        dout.num  = 2'd1;
        dout.res0 = '{data_byte: byte_val, run_last: 1'b1,
                      message_end: 1'b1, bad_char: 1'b0};
      end else if (have_byte) begin
        // finished byte first, then the zero-padded leftover bits
        dout.num  = 2'd2;
        dout.res0 = '{data_byte: byte_val, run_last: 1'b0,
                      message_end: 1'b0, bad_char: 1'b0};
        dout.res1 = '{data_byte: pb_nxt, run_last: 1'b1,
                      message_end: 1'b1, bad_char: 1'b0};
      end else begin
        dout.num  = 2'd1;
        dout.res0 = '{data_byte: pb_nxt, run_last: 1'b1,
                      message_end: 1'b1, bad_char: 1'b0};
      end
    end
  end

endmodule

// File: hw/rtl/custom_alphabet_base64_decoder.sv
// custom_alphabet_base64_decoder: top level, input register, decoder state, result queue
// depends on b64d_pkg and b64d_decode
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   char_code[7:0], end_of_message
//   out_     output     out_valid/out_stall data_byte[7:0], run_last, message_end, bad_char
//
// one character per cycle while the queue has room; an item is decoded combinationally
// from the input register and its results sit in a four-entry queue before leaving
// an end-mark item may give two results, which drain one per cycle while out_stall is low
// the input register holds while the queue has fewer than two free entries
// synchronous active-low reset clears the decoder state and empties the queue
module custom_alphabet_base64_decoder import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_message,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_run_last,
  output logic       out_message_end,
  output logic       out_bad_char
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  logic             s1_valid_r;
  logic [7:0]       s1_char_r;
  logic             s1_eom_r;
  dec_state_t       st_r, st_nxt;
  dec_out_t         dout;
  result_t          q_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     cnt_r;
  logic             adv;
  logic             push;
  logic             pop;
  logic             in_acc;

  b64d_decode u_dec (
    .char_code      (s1_char_r),
    .end_of_message (s1_eom_r),
    .st             (st_r),
    .st_nxt         (st_nxt),
    .dout           (dout)
  );

  // room for the worst case of two results
  assign adv      = (cnt_r <= (QAW+1)'(QDEPTH - 2));
  assign push     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = (cnt_r != '0);
  assign pop      = out_valid && !out_stall;

  assign out_data_byte   = q_r[rd_ptr_r].data_byte;
  assign out_run_last    = q_r[rd_ptr_r].run_last;
  assign out_message_end = q_r[rd_ptr_r].message_end;
  assign out_bad_char    = q_r[rd_ptr_r].bad_char;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      st_r       <= '0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (push) begin
        s1_valid_r <= 1'b0;
      end
      if (push) begin
        st_r     <= st_nxt;
        wr_ptr_r <= wr_ptr_r + QAW'(dout.num);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      cnt_r <= cnt_r + (push ? (QAW+1)'(dout.num) : '0) - (QAW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r <= in_char_code;
      s1_eom_r  <= in_end_of_message;
    end
    if (push && dout.num != 2'd0) begin
      q_r[wr_ptr_r] <= dout.res0;
    end
    if (push && dout.num == 2'd2) begin
      q_r[wr_ptr_r + QAW'(1)] <= dout.res1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH))
    else $error("result queue count out of range");

  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.drop_until_end |-> (st_r.phase == 2'd0 && st_r.partial_byte == 8'h00))
    else $error("decoder state not cleared while dropping");

  a_bad_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_char) |->
      (out_message_end && out_run_last && out_data_byte == 8'h00))
    else $error("error result malformed");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_message_end) |-> out_run_last)
    else $error("message end without run_last");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && cnt_r > (QAW+1)'(QDEPTH - 2)))
    else $error("input stalled with queue room");

endmodule

// File: verif/b64d_decode_scoreboard_pkg.sv
`timescale 1ns / 100ps
// scoreboard for the custom-alphabet base64 decoder: tracks decode state and expected bytes
// depends on b64d_pkg for the character constants and value bases
package b64d_decode_scoreboard_pkg;
  import b64d_pkg::*;

  // 6-bit code of a character, -1 when it is outside the alphabet
  function automatic int symbol_code(logic [7:0] c);
    if (c >= CH_LOW_A && c <= CH_LOW_Z) return int'(c - CH_LOW_A);
    if (c >= CH_UP_A && c <= CH_UP_Z) return int'(VAL_UP_BASE) + int'(c - CH_UP_A);
    if (c >= CH_DIG_0 && c <= CH_DIG_9) return int'(VAL_DIG_BASE) + int'(c - CH_DIG_0);
    if (c == CH_LBRACK) return int'(VAL_LBRACK);
    if (c == CH_RBRACK) return int'(VAL_RBRACK);
    return -1;
  endfunction

  class b64d_decode_scoreboard;
    logic [1:0] phase;
    logic [7:0] partial_byte;
    bit         dropping;
    result_t    expected_bytes_q[$];
    int unsigned failures;

    function new();
      phase = '0;
      partial_byte = '0;
      dropping = 1'b0;
      failures = 0;
    endfunction

    function void push_byte(logic [7:0] d, logic rl, logic me, logic bc);
      result_t r;
      r.data_byte = d;
      r.run_last = rl;
      r.message_end = me;
      r.bad_char = bc;
      // append at the tail
      expected_bytes_q.insert(expected_bytes_q.size(), r);
    endfunction

    // advance the decode state by one accepted item
    function void decode_char(logic [7:0] c, logic eom);
      int v;
      logic [5:0] u;
      logic [7:0] byte_val;
      bit have_byte;
      byte_val = '0;
      have_byte = 1'b0;
      if (dropping) begin
        if (eom) dropping = 1'b0;
        return;
      end
      v = symbol_code(c);
      if (v < 0) begin
        push_byte(8'h00, 1'b1, 1'b1, 1'b1);
        phase = '0;
        partial_byte = '0;
        dropping = !eom;
        return;
      end
      u = v[5:0];
      case (phase)
        2'd0: begin
          partial_byte = {u, 2'b00};
        end
        2'd1: begin
          byte_val = partial_byte | {6'b0, u[5:4]};
          have_byte = 1'b1;
          partial_byte = {u[3:0], 4'b0};
        end
        2'd2: begin
          byte_val = partial_byte | {4'b0, u[5:2]};
          have_byte = 1'b1;
          partial_byte = {u[1:0], 6'b0};
        end
        default: begin
          byte_val = partial_byte | {2'b0, u};
          have_byte = 1'b1;
          partial_byte = '0;
        end
      endcase
      if (!eom) begin
        phase = phase + 2'd1;
        if (have_byte) push_byte(byte_val, 1'b1, 1'b0, 1'b0);
        return;
      end
      if (phase == PHASE_LAST) begin
        push_byte(byte_val, 1'b1, 1'b1, 1'b0);
      end else begin
        // leftover bits go out zero padded after any byte of this step
        if (have_byte) push_byte(byte_val, 1'b0, 1'b0, 1'b0);
        push_byte(partial_byte, 1'b1, 1'b1, 1'b0);
      end
      phase = '0;
      partial_byte = '0;
    endfunction

    function void check_result(logic [7:0] d, logic rl, logic me, logic bc);
      result_t exp_r;
      if (expected_bytes_q.size() == 0) begin
        $error("unexpected result: data_byte %0h run_last %0b message_end %0b bad_char %0b",
               d, rl, me, bc);
        failures++;
        return;
      end
      exp_r = expected_bytes_q.pop_front();
      if (d !== exp_r.data_byte) begin
        $error("data_byte: expected %0h, got %0h", exp_r.data_byte, d);
        failures++;
      end
      if (rl !== exp_r.run_last) begin
        $error("run_last: expected %0b, got %0b", exp_r.run_last, rl);
        failures++;
      end
      if (me !== exp_r.message_end) begin
        $error("message_end: expected %0b, got %0b", exp_r.message_end, me);
        failures++;
      end
      if (bc !== exp_r.bad_char) begin
        $error("bad_char: expected %0b, got %0b", exp_r.bad_char, bc);
        failures++;
      end
    endfunction

    function int pending();
      return expected_bytes_q.size();
    endfunction
  endclass

endpackage

// File: verif/tb_custom_alphabet_base64_decoder.sv
`timescale 1ns / 100ps
// testbench top for custom_alphabet_base64_decoder: directed and random character streams
// depends on b64d_pkg, b64d_decode_scoreboard_pkg and the decoder rtl
module tb_custom_alphabet_base64_decoder;
  import b64d_pkg::*;
  import b64d_decode_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int RANDOM_ITEMS   = 700;
  localparam int HOLDOFF_CYCLES = 80;
  localparam int DRAIN_CYCLES   = 20;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_code = 8'h00;
  logic       in_end_of_message = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_data_byte;
  logic       out_run_last;
  logic       out_message_end;
  logic       out_bad_char;

  b64d_decode_scoreboard sb;
  int  sent_count = 0;
  int  cycle_count = 0;
  bit  quiet = 1'b0;
  bit  holdoff_req = 1'b0;

  custom_alphabet_base64_decoder uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char_code(in_char_code),
    .in_end_of_message(in_end_of_message),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data_byte(out_data_byte),
    .out_run_last(out_run_last),
    .out_message_end(out_message_end),
    .out_bad_char(out_bad_char)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_data_byte, out_run_last, out_message_end, out_bad_char);
  end

  // receiver stalls; a long hold-off on each request so the block backs up
  initial begin
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end
      out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 24);
    end
  end

  task automatic send_char(input logic [7:0] c, input logic eom);
    while (!quiet && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    in_end_of_message <= eom;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.decode_char(c, eom);
    sent_count++;
  endtask

  function automatic logic [7:0] char_of_code(int v);
    if (v < 26) return CH_LOW_A + 8'(v);
    if (v < 52) return CH_UP_A + 8'(v - 26);
    if (v < 62) return CH_DIG_0 + 8'(v - 52);
    if (v == 62) return CH_LBRACK;
    return CH_RBRACK;
  endfunction

  function automatic logic [7:0] random_bad_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (symbol_code(c) >= 0);
    return c;
  endfunction

  // mostly clean messages; some carry a bad character followed by junk
  task automatic send_message();
    int len;
    int bad_at;
    logic [7:0] c;
    len = $urandom_range(1, 12);
    bad_at = ($urandom_range(99) < 15) ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      if (i == bad_at) c = random_bad_char();
      else if (bad_at >= 0 && i > bad_at && $urandom_range(1)) c = 8'($urandom_range(255));
      else c = char_of_code($urandom_range(63));
      send_char(c, i == len - 1);
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // end mark in phase 3, then phase 0, phase 1, phase 2
    send_char(CH_LOW_A, 1'b0);
    send_char(CH_LOW_Z, 1'b0);
    send_char(CH_UP_A, 1'b0);
    send_char(CH_UP_Z, 1'b1);
    send_char(CH_DIG_0, 1'b0);
    send_char(CH_DIG_9, 1'b0);
    send_char(CH_LBRACK, 1'b0);
    send_char(CH_RBRACK, 1'b0);
    send_char(CH_RBRACK, 1'b1);
    send_char(CH_UP_Z, 1'b0);
    send_char(CH_LOW_A, 1'b1);
    send_char(CH_RBRACK, 1'b0);
    send_char(CH_LBRACK, 1'b0);
    send_char(CH_DIG_9, 1'b1);
    // bad character mid message, then dropped items up to the end mark
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(CH_LOW_A, 1'b0);
    send_char(CH_LOW_A + 8'd1, 1'b1);
    // bad character carrying the end mark, no dropping after it
    send_char(CH_LOW_A + 8'd16, 1'b0);
    send_char(8'hff, 1'b1);
    send_char(CH_LOW_A + 8'd10, 1'b1);
    send_char(8'h5c, 1'b1);
    send_char(8'h7f, 1'b1);

    sent_count = 0;
    while (sent_count < RANDOM_ITEMS) begin
      if (sent_count >= 250 && sent_count < 260) holdoff_req = 1'b1;
      quiet = (sent_count >= 450 && sent_count < 560);
      if ($urandom_range(99) < 8)
        send_char(8'($urandom_range(255)), $urandom_range(3) == 0);
      else
        send_message();
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_decode.sv
hw/rtl/custom_alphabet_base64_decoder.sv
verif/b64d_decode_scoreboard_pkg.sv
verif/tb_custom_alphabet_base64_decoder.sv
